FILE: sv/sas_pkg.sv
// Package for the slot allocator: transaction codes, controller states and
// fixed field widths. No dependencies; imported by the top level and the testbench.

package sas_pkg;

    localparam int DEF_MAX_SLOTS  = 256;
    localparam int DEF_DATA_WIDTH = 64;
    localparam int SLOT_W         = 8;
    localparam int COUNT_W        = 9;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 3;
    localparam int RESET_ACTIVE   = 256;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_WRITE   = 2'd2,
        MODE_READ    = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 3'd0,
        STATUS_ILLEGAL    = 3'd1,
        STATUS_NO_ELEMENT = 3'd2,
        STATUS_FULL       = 3'd3,
        STATUS_NOT_IN_USE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_CLEAR = 2'd2
    } t_state;

endpackage

FILE: sv/slot_allocator_with_store.sv
// Slot allocator top level: LIFO free-slot stack, in-use marks and per-slot data.
// Depends on sas_pkg and three sas_ram instances (stack, marks, data).
//
//  channel   direction  handshake                     payload
//  command   in         start & !busy                 i_mode, i_slot, i_write_data
//  result    out        o_done, one cycle, no stall   o_status, o_alloc_slot,
//                                                     o_read_data, o_used_count
//  config    in         i_cfg_we                      i_cfg_data (active slots)
//
// In each transaction the accept cycle reads the mark, data and stack RAMs,
// and the next cycle checks, writes back and registers the result. busy is
// high in that execute cycle, so no new command is accepted until it is done.
// o_done is registered from the execute state; the receiver cannot stall it.
// After reset and after every config write a clearing pass over all MAX_SLOTS
// entries zeroes marks and data while busy is high. The free stack is not
// cleared: a low-water mark tells which entries still hold their initial value.

module slot_allocator_with_store
    import sas_pkg::*;
#(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [DATA_WIDTH-1:0] i_write_data,
    input  logic                  i_cfg_we,
    input  logic [COUNT_W-1:0]    i_cfg_data,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [SLOT_W-1:0]     o_alloc_slot,
    output logic [DATA_WIDTH-1:0] o_read_data,
    output logic [COUNT_W-1:0]    o_used_count
);

    localparam int IDX_W    = $clog2(MAX_SLOTS);
    localparam int CNT_BITS = $clog2(MAX_SLOTS + 1);
    localparam int CW       = (CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W;
    localparam logic [CW-1:0]    MAX_CNT  = CW'(MAX_SLOTS);
    localparam logic [CW-1:0]    RST_CNT  = (MAX_SLOTS < RESET_ACTIVE) ?
                                            CW'(MAX_SLOTS) : CW'(RESET_ACTIVE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

    t_state r_state, n_state;
    logic [CW-1:0]    r_active;
    logic [CW-1:0]    r_depth, n_depth;
    logic [CW-1:0]    r_low, n_low;     // stack entries at or above this were written
    logic [IDX_W-1:0] r_clr_idx;

    t_mode                 r_mode;
    logic [SLOT_W-1:0]     r_slot;
    logic [DATA_WIDTH-1:0] r_wdata;

    logic                  r_done;
    t_status               r_status, n_status;
    logic [SLOT_W-1:0]     r_alloc, n_alloc;
    logic [DATA_WIDTH-1:0] r_rdata, n_rdata;
    logic [COUNT_W-1:0]    r_used;

    logic [CW-1:0]    cfg_cnt;
    logic             accept;
    logic [CW-1:0]    pos;
    logic             in_range;
    logic [IDX_W-1:0] given_idx;

    logic                  mark_we, mark_wdata, mark_q;
    logic [IDX_W-1:0]      mark_waddr;
    logic                  data_we;
    logic [IDX_W-1:0]      data_waddr;
    logic [DATA_WIDTH-1:0] data_wdata, data_q;
    logic                  stk_we;
    logic [IDX_W-1:0]      stk_q;

    assign busy   = (r_state != ST_IDLE) || !i_rst_n;
    assign accept = start && !busy;

    always_comb begin
        cfg_cnt = CW'(i_cfg_data);
        if (cfg_cnt == '0) begin
            cfg_cnt = CW'(1);
        end else if (cfg_cnt > MAX_CNT) begin
            cfg_cnt = MAX_CNT;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_we) begin
                    n_state = ST_CLEAR;
                end else if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = i_cfg_we ? ST_CLEAR : ST_IDLE;
            end
            ST_CLEAR: begin
                if (!i_cfg_we && r_clr_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // execute stage and RAM write controls
    always_comb begin
        pos       = r_depth - CW'(1);
        in_range  = CW'(r_slot) < r_active;
        given_idx = (pos < r_low) ? IDX_W'(r_active - CW'(1) - pos) : stk_q;

        mark_we    = 1'b0;
        mark_waddr = IDX_W'(r_slot);
        mark_wdata = 1'b0;
        data_we    = 1'b0;
        data_waddr = IDX_W'(r_slot);
        data_wdata = r_wdata;
        stk_we     = 1'b0;
        n_depth    = r_depth;
        n_low      = r_low;
        n_status   = STATUS_OK;
        n_alloc    = '0;
        n_rdata    = '0;

        unique case (r_state)
            ST_CLEAR: begin
                mark_we    = 1'b1;
                mark_waddr = r_clr_idx;
                data_we    = 1'b1;
                data_waddr = r_clr_idx;
                data_wdata = '0;
            end
            ST_EXEC: begin
                unique case (r_mode)
                    MODE_ALLOC: begin
                        if (r_depth == '0) begin
                            n_status = STATUS_FULL;
                        end else begin
                            mark_we    = 1'b1;
                            mark_waddr = given_idx;
                            mark_wdata = 1'b1;
                            n_alloc    = SLOT_W'(given_idx);
                            n_depth    = pos;
                            if (pos < r_low) begin
                                n_low = pos;
                            end
                        end
                    end
                    MODE_RELEASE: begin
                        if (!in_range || !mark_q || r_depth >= r_active) begin
                            n_status = STATUS_NO_ELEMENT;
                        end else begin
                            mark_we = 1'b1;
                            stk_we  = 1'b1;
                            n_depth = r_depth + CW'(1);
                        end
                    end
                    MODE_WRITE, MODE_READ: begin
                        if (!in_range) begin
                            n_status = STATUS_ILLEGAL;
                        end else if (!mark_q) begin
                            n_status = STATUS_NOT_IN_USE;
                        end else if (r_mode == MODE_WRITE) begin
                            data_we = 1'b1;
                        end else begin
                            n_rdata = data_q;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_active  <= RST_CNT;
            r_depth   <= RST_CNT;
            r_low     <= RST_CNT;
            r_clr_idx <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_EXEC);
            if (i_cfg_we) begin
                r_active  <= cfg_cnt;
                r_depth   <= cfg_cnt;
                r_low     <= cfg_cnt;
                r_clr_idx <= '0;
            end else begin
                r_depth <= n_depth;
                r_low   <= n_low;
                if (r_state == ST_CLEAR) begin
                    r_clr_idx <= r_clr_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= t_mode'(i_mode);
            r_slot  <= i_slot;
            r_wdata <= i_write_data;
        end
        if (r_state == ST_EXEC) begin
            r_status <= n_status;
            r_alloc  <= n_alloc;
            r_rdata  <= n_rdata;
            r_used   <= COUNT_W'(r_active - n_depth);
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_alloc_slot = r_alloc;
    assign o_read_data  = r_rdata;
    assign o_used_count = r_used;

    sas_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (IDX_W'(i_slot)),
        .o_rdata (mark_q)
    );

    sas_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (IDX_W'(i_slot)),
        .o_rdata (data_q)
    );

    sas_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (IDX_W'(r_depth)),
        .i_wdata (IDX_W'(r_slot)),
        .i_raddr (IDX_W'(pos)),
        .o_rdata (stk_q)
    );

    a_done_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> o_done)
        else $error("result strobe missing after execute cycle");

    a_done_only_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_EXEC))
        else $error("result strobe without a transaction");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_low <= r_depth) && (r_depth <= r_active))
        else $error("free stack depth out of bounds");

    a_full_means_all_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STATUS_FULL) |-> (o_used_count == COUNT_W'(r_active)))
        else $error("full reported with free slots left");

endmodule

FILE: sv/sas_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.

module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

FILE: test/tb.sv
// Self-checking testbench for slot_allocator_with_store: directed and random commands,
// several active-slot settings, with results checked against a free-stack predictor.
// Depends on sas_pkg and the slot_allocator_with_store RTL only.

module tb;
    import sas_pkg::*;

    localparam int SLOTS       = DEF_MAX_SLOTS;
    localparam int DW          = DEF_DATA_WIDTH;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  alloc_slot;
        logic [DW-1:0]      read_data;
        logic [COUNT_W-1:0] used_count;
    } t_outcome;

    // Mirrors the free stack, the in-use marks and the data words
    class slot_tracker;
        int unsigned        active;
        logic [SLOT_W-1:0]  free_stack [SLOTS];
        int unsigned        free_depth;
        bit                 in_use [SLOTS];
        logic [DW-1:0]      slot_data [SLOTS];
        t_outcome           awaited [$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        status_seen [5];

        function void reload(logic [COUNT_W-1:0] value);
            int unsigned count;
            count = value;
            if (count < 1) count = 1;
            if (count > SLOTS) count = SLOTS;
            active = count;
            for (int i = 0; i < SLOTS; i++) begin
                free_stack[i] = (i < count) ? SLOT_W'(count - 1 - i) : '0;
                in_use[i]     = 1'b0;
                slot_data[i]  = '0;
            end
            free_depth = count;
        endfunction

        function void note_command(t_mode mode, logic [SLOT_W-1:0] slot, logic [DW-1:0] wdata);
            t_outcome res;
            bit       in_range;
            res.status     = STATUS_OK;
            res.alloc_slot = '0;
            res.read_data  = '0;
            in_range       = (slot < active);
            case (mode)
                MODE_ALLOC: begin
                    if (free_depth == 0) begin
                        res.status = STATUS_FULL;
                    end else begin
                        free_depth--;
                        res.alloc_slot = free_stack[free_depth];
                        in_use[res.alloc_slot] = 1'b1;
                    end
                end
                MODE_RELEASE: begin
                    if (!in_range || !in_use[slot] || free_depth >= active) begin
                        res.status = STATUS_NO_ELEMENT;
                    end else begin
                        in_use[slot] = 1'b0;
                        free_stack[free_depth] = slot;
                        free_depth++;
                    end
                end
                default: begin
                    if (!in_range) begin
                        res.status = STATUS_ILLEGAL;
                    end else if (!in_use[slot]) begin
                        res.status = STATUS_NOT_IN_USE;
                    end else if (mode == MODE_WRITE) begin
                        slot_data[slot] = wdata;
                    end else begin
                        res.read_data = slot_data[slot];
                    end
                end
            endcase
            res.used_count = COUNT_W'(active - free_depth);
            awaited.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] alloc_slot,
                                   logic [DW-1:0] read_data, logic [COUNT_W-1:0] used_count);
            t_outcome want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d alloc_slot %0d used_count %0d",
                             status, alloc_slot, used_count);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (status < 5) status_seen[status]++;
            if (status !== want.status || alloc_slot !== want.alloc_slot ||
                read_data !== want.read_data || used_count !== want.used_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch %0d (expected/actual): status %0d/%0d alloc_slot %0d/%0d",
                             mismatches, want.status, status, want.alloc_slot, alloc_slot);
                    $display("  read_data %h/%h used_count %0d/%0d",
                             want.read_data, read_data, want.used_count, used_count);
                end
            end
        endfunction

        // A slot currently handed out, or any active slot if none is
        function logic [SLOT_W-1:0] pick_in_use();
            logic [SLOT_W-1:0] taken [$];
            for (int i = 0; i < SLOTS; i++)
                if (in_use[i]) taken.push_back(SLOT_W'(i));
            if (taken.size() == 0) return SLOT_W'($urandom_range(active - 1));
            return taken[$urandom_range(taken.size() - 1)];
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic [MODE_W-1:0]   i_mode       = '0;
    logic [SLOT_W-1:0]   i_slot       = '0;
    logic [DW-1:0]       i_write_data = '0;
    logic                i_cfg_we     = 1'b0;
    logic [COUNT_W-1:0]  i_cfg_data   = '0;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_alloc_slot;
    logic [DW-1:0]       o_read_data;
    logic [COUNT_W-1:0]  o_used_count;

    slot_tracker tracker;
    bit          idle_en = 1'b1;
    int unsigned sent;
    int unsigned settings_used;
    int unsigned quiet_cycles;

    slot_allocator_with_store u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_slot       (i_slot),
        .i_write_data (i_write_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_alloc_slot (o_alloc_slot),
        .o_read_data  (o_read_data),
        .o_used_count (o_used_count)
    );

    always #5 i_clk = ~i_clk;

    // Result checking and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            tracker.check_result(o_status, o_alloc_slot, o_read_data, o_used_count);
        if ((start && busy === 1'b0) || o_done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_cmd(input t_mode m, input logic [SLOT_W-1:0] s, input logic [DW-1:0] d);
        while (idle_en && $urandom_range(99) < 31) begin
            @(negedge i_clk);
            start <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_mode       <= m;
        i_slot       <= s;
        i_write_data <= d;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_command(m, s, d);
        sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [COUNT_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        tracker.reload(value);
        settings_used++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic on slots in use, the rest random noise
    task automatic run_phase(input logic [COUNT_W-1:0] setting, input int items,
                             input int alloc_pct, input bit idle, input bit mid_drain);
        int                r;
        t_mode             m;
        logic [SLOT_W-1:0] s;
        logic [DW-1:0]     d;
        write_active(setting);
        idle_en = idle;
        for (int n = 0; n < items; n++) begin
            d = {$urandom, $urandom};
            s = SLOT_W'($urandom_range(255));
            if ($urandom_range(99) < alloc_pct) begin
                m = MODE_ALLOC;
            end else begin
                r = $urandom_range(99);
                if (r < 85) s = tracker.pick_in_use();
                if (r < 35)      m = MODE_RELEASE;
                else if (r < 60) m = MODE_WRITE;
                else if (r < 85) m = MODE_READ;
                else             m = t_mode'($urandom_range(3));
            end
            if (mid_drain && n == items / 2) wait_drained();
            send_cmd(m, s, d);
        end
    endtask

    initial begin
        tracker = new();
        tracker.reload(COUNT_W'(RESET_ACTIVE));
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-slot errors, data extremes, full stack, range checks
        send_cmd(MODE_READ,    8'd0,   '0);
        send_cmd(MODE_RELEASE, 8'd0,   '0);
        send_cmd(MODE_WRITE,   8'd255, '1);
        send_cmd(MODE_ALLOC,   8'd0,   '0);
        send_cmd(MODE_WRITE,   8'd0,   '1);
        send_cmd(MODE_READ,    8'd0,   '0);
        send_cmd(MODE_WRITE,   8'd0,   '0);
        send_cmd(MODE_READ,    8'd0,   '1);
        send_cmd(MODE_RELEASE, 8'd0,   '0);
        write_active(9'd2);
        send_cmd(MODE_ALLOC,   8'd0,   '0);
        send_cmd(MODE_ALLOC,   8'd0,   '0);
        send_cmd(MODE_ALLOC,   8'd0,   '0);
        send_cmd(MODE_WRITE,   8'd2,   '1);
        send_cmd(MODE_READ,    8'd255, '0);
        send_cmd(MODE_RELEASE, 8'd200, '0);
        send_cmd(MODE_RELEASE, 8'd1,   '0);
        send_cmd(MODE_RELEASE, 8'd1,   '0);
        send_cmd(MODE_ALLOC,   8'd0,   '0);
        // zero acts as one slot
        write_active(9'd0);
        send_cmd(MODE_ALLOC,   8'd0,   '0);
        send_cmd(MODE_ALLOC,   8'd0,   '0);
        send_cmd(MODE_READ,    8'd1,   '0);
        // above the maximum acts as the maximum; marks and data cleared
        write_active(9'd511);
        send_cmd(MODE_READ,    8'd0,   '0);
        send_cmd(MODE_ALLOC,   8'd0,   '0);
        send_cmd(MODE_READ,    8'd0,   '0);

        run_phase(9'd8,   90,  35, 1'b1, 1'b0);
        run_phase(9'd1,   60,  40, 1'b1, 1'b0);
        run_phase(9'd256, 300, 92, 1'b0, 1'b0);
        run_phase(9'd3,   90,  35, 1'b1, 1'b1);
        run_phase(9'd511, 150, 50, 1'b1, 1'b0);
        run_phase(9'd16,  100, 45, 1'b1, 1'b0);
        run_phase(COUNT_W'($urandom_range(511)), 90, 50, 1'b1, 1'b0);
        run_phase(9'd0,   40,  40, 1'b1, 1'b0);
        run_phase(9'd40,  120, 55, 1'b1, 1'b0);
        run_phase(9'd2,   90,  35, 1'b1, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d commands over %0d slot-count settings; %0d results checked",
                 sent, settings_used, tracker.checked);
        $display("Status mix: ok %0d, illegal %0d, no element %0d, full %0d, not in use %0d",
                 tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
                 tracker.status_seen[3], tracker.status_seen[4]);
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
